[src/pwlcr_pkg.sv]
// Shared types and constants of the piecewise-linear colour ramp.
`default_nettype none

package pwlcr_pkg;

  localparam int MAX_POINTS_DEF = 32;
  localparam int LUT_SIZE_DEF   = 256;

  localparam int LEVEL_W    = 16;
  localparam int COUNT_W    = 6;
  localparam int SLOT_W     = 5;
  localparam int LUT_IDX_W  = 8;
  localparam int COLOUR_W   = 32;
  localparam int LANES      = 4;
  localparam int POINT_W    = LANES * LEVEL_W;
  localparam int DIV_STEPS  = 16;
  localparam int STEP_W     = $clog2(DIV_STEPS);

  localparam logic [COUNT_W-1:0] COUNT_RESET = 6'd2;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_MAP   = 1'b1;

  typedef struct packed {
    logic wr_point;
    logic map_start;
    logic div_step;
    logic srch_start;
    logic srch;
    logic load0;
    logic load1;
    logic mul_step;
    logic fin;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic srch_stop;
    logic mul_last;
  } status_t;

endpackage

`default_nettype wire

[src/pwlcr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module pwlcr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[src/pwlcr_ctrl.sv]
// Controller state machine that sequences one request through the datapath.
`default_nettype none

module pwlcr_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic              kind_i,
  input  wire pwlcr_pkg::status_t stat_i,
  output      pwlcr_pkg::cmd_t   cmd_o,
  output      logic              busy_o
);

  localparam logic [3:0] StIdle   = 4'd0;
  localparam logic [3:0] StSrch0  = 4'd2;
  localparam logic [3:0] StSrch   = 4'd3;
  localparam logic [3:0] StLoad0  = 4'd4;
  localparam logic [3:0] StLoad1  = 4'd5;
  localparam logic [3:0] StMul    = 4'd6;
  localparam logic [3:0] StDiv    = 4'd7;
  localparam logic [3:0] StFin    = 4'd8;
  localparam logic [3:0] StEmit   = 4'd9;

  logic [3:0] state_q, state_d;
  logic       accept;

  assign accept = start_i && (state_q == StIdle);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        cmd_o.wr_point  = accept && (kind_i == pwlcr_pkg::KIND_WRITE);
        cmd_o.map_start = accept && (kind_i == pwlcr_pkg::KIND_MAP);
        if (accept && (kind_i == pwlcr_pkg::KIND_MAP)) begin
          state_d = StSrch0;
        end
      end
      StSrch0: begin
        cmd_o.srch_start = 1'b1;
        state_d          = StSrch;
      end
      StSrch: begin
        cmd_o.srch = 1'b1;
        if (stat_i.srch_stop) begin
          state_d = StLoad0;
        end
      end
      StLoad0: begin
        cmd_o.load0 = 1'b1;
        state_d     = StLoad1;
      end
      StLoad1: begin
        cmd_o.load1 = 1'b1;
        state_d     = StMul;
      end
      StMul: begin
        cmd_o.mul_step = 1'b1;
        if (stat_i.mul_last) begin
          state_d = StDiv;
        end
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          state_d = StFin;
        end
      end
      StFin: begin
        cmd_o.fin = 1'b1;
        state_d   = StEmit;
      end
      StEmit: begin
        cmd_o.emit = 1'b1;
        state_d    = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != StIdle);

endmodule

`default_nettype wire

[src/pwlcr_dpath.sv]
// Datapath: point stores, segment search, multiplier, divider lanes and rounding.
`default_nettype none

module pwlcr_dpath #(
  parameter int MAX_POINTS = pwlcr_pkg::MAX_POINTS_DEF,
  parameter int LUT_SIZE   = pwlcr_pkg::LUT_SIZE_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire pwlcr_pkg::cmd_t                     cmd_i,
  output      pwlcr_pkg::status_t                  stat_o,
  input  wire logic                                cfg_we_i,
  input  wire logic [pwlcr_pkg::COUNT_W-1:0]       cfg_wdata_i,
  input  wire logic [pwlcr_pkg::SLOT_W-1:0]        point_slot_i,
  input  wire logic [pwlcr_pkg::LEVEL_W-1:0]       point_position_i,
  input  wire logic [pwlcr_pkg::LEVEL_W-1:0]       red_level_i,
  input  wire logic [pwlcr_pkg::LEVEL_W-1:0]       green_level_i,
  input  wire logic [pwlcr_pkg::LEVEL_W-1:0]       blue_level_i,
  input  wire logic [pwlcr_pkg::LEVEL_W-1:0]       alpha_level_i,
  input  wire logic [pwlcr_pkg::LUT_IDX_W-1:0]     lut_index_i,
  output      logic                                result_strobe_o,
  output      logic [pwlcr_pkg::COLOUR_W-1:0]      packed_colour_o
);

  localparam int AW         = $clog2(MAX_POINTS);
  localparam int LANES      = pwlcr_pkg::LANES;
  localparam int LW         = pwlcr_pkg::LEVEL_W;
  localparam int LutEntries = 2 ** pwlcr_pkg::LUT_IDX_W;
  localparam int IdxMax     = (LUT_SIZE - 1 < LutEntries - 1) ? LUT_SIZE - 1 : LutEntries - 1;
  localparam logic [8:0]    MaxPts9   = 9'(MAX_POINTS);
  localparam logic [pwlcr_pkg::STEP_W-1:0] LastStep =
    pwlcr_pkg::STEP_W'(pwlcr_pkg::DIV_STEPS - 1);
  localparam logic [2:0]    LastCh    = 3'(LANES);

  function automatic logic [7:0] level_to_byte(input logic [LW-1:0] v);
    logic [23:0] x;
    logic [16:0] t;
    x = {v, 8'b0} - {8'b0, v} + 24'd32767;
    t = {1'b0, x[15:0]} + {9'b0, x[23:16]};
    return (t >= 17'd65535) ? (x[23:16] + 8'd1) : x[23:16];
  endfunction

  // Configuration and stores.
  logic [pwlcr_pkg::COUNT_W-1:0] count_q;
  logic                          slot_ok;
  logic                          ram_we;
  logic [AW-1:0]                 waddr;
  logic [AW-1:0]                 paddr, caddr;
  logic [LW-1:0]                 prdata;
  logic [pwlcr_pkg::POINT_W-1:0] crdata;

  assign slot_ok = ({4'b0, point_slot_i} < MaxPts9);
  assign ram_we  = cmd_i.wr_point && slot_ok;
  assign waddr   = AW'(point_slot_i);

  pwlcr_ram #(.WIDTH(LW), .DEPTH(MAX_POINTS)) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr),
    .wdata_i (point_position_i),
    .raddr_i (paddr),
    .rdata_o (prdata)
  );

  pwlcr_ram #(.WIDTH(pwlcr_pkg::POINT_W), .DEPTH(MAX_POINTS)) u_col_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr),
    .wdata_i ({alpha_level_i, blue_level_i, green_level_i, red_level_i}),
    .raddr_i (caddr),
    .rdata_o (crdata)
  );

  // Position of every LUT index, indexes past the end held at the last entry.
  logic [LW-1:0] pos_lut [LutEntries];

  for (genvar i = 0; i < LutEntries; i++) begin : g_pos
    localparam int Ic = (i > IdxMax) ? IdxMax : i;
    assign pos_lut[i] = LW'((Ic * 65535) / (LUT_SIZE - 1));
  end

  // Segment search.
  logic [8:0]    cnt9, n9;
  logic [AW-1:0] nm1;
  logic [AW-1:0] k_q;
  logic          cont;
  logic [LW-1:0] pos_q, p0_q, p1_q;

  assign cnt9 = {3'b0, count_q};
  assign n9   = (cnt9 < 9'd2) ? 9'd2 : ((cnt9 > MaxPts9) ? MaxPts9 : cnt9);
  assign nm1  = AW'(n9 - 9'd1);
  assign cont = (k_q < nm1) && (pos_q > prdata);

  always_comb begin
    paddr = '0;
    caddr = '0;
    if (cmd_i.srch_start) begin
      paddr = AW'(1);
    end else if (cmd_i.srch) begin
      paddr = cont ? (k_q + AW'(1)) : (k_q - AW'(1));
      caddr = k_q;
    end else if (cmd_i.load0) begin
      caddr = k_q - AW'(1);
    end
  end

  // Segment operands.
  logic [pwlcr_pkg::POINT_W-1:0] c0_q, c1_q;
  logic [LW:0]                   span_q;
  logic [LW-1:0]                 den_q;
  logic [LW-1:0]                 dmag_q;
  logic                          dneg_q;
  logic [LW:0]                   dpos;

  assign dpos = {1'b0, pos_q} - {1'b0, p0_q};

  // Shared multiplier, one channel a cycle.
  logic [2:0]    ch_q;
  logic [1:0]    mul_ch;
  logic [LW-1:0] mc0, mc1;
  logic [LW:0]   dc;
  logic [LW-1:0] dcmag;
  logic [31:0]   prod_q;
  logic          prod_neg_q;
  logic [1:0]    prod_ch_q;
  logic          prod_vld_q;
  logic          ovf;

  assign mul_ch = ch_q[1:0];
  assign mc0    = c0_q[16*mul_ch +: 16];
  assign mc1    = c1_q[16*mul_ch +: 16];
  assign dc     = {1'b0, mc1} - {1'b0, mc0};
  assign dcmag  = dc[LW] ? LW'(-dc) : dc[LW-1:0];
  assign ovf    = (prod_q[31:16] >= den_q);

  // Divider lanes.
  logic [LW-1:0]               rem_q  [LANES];
  logic [LW-1:0]               quo_q  [LANES];
  logic                        ovf_q  [LANES];
  logic                        neg_q  [LANES];
  logic [pwlcr_pkg::STEP_W-1:0] step_q;
  logic [LW:0]                 trial  [LANES];
  logic                        take   [LANES];
  logic [LW-1:0]               v_d    [LANES];
  logic [LW-1:0]               v_q    [LANES];
  logic                        span_pos;

  assign span_pos = !span_q[LW] && (span_q != '0);

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      logic [LW+1:0] vs;
      trial[l] = {rem_q[l], quo_q[l][LW-1]};
      take[l]  = (trial[l] >= {1'b0, den_q});
      vs = neg_q[l] ? ({2'b0, c0_q[16*l +: 16]} - {2'b0, quo_q[l]})
                    : ({2'b0, c0_q[16*l +: 16]} + {2'b0, quo_q[l]});
      if (!span_pos) begin
        v_d[l] = c0_q[16*l +: 16];
      end else if (ovf_q[l]) begin
        v_d[l] = neg_q[l] ? '0 : '1;
      end else if (vs[LW+1]) begin
        v_d[l] = '0;
      end else if (vs[LW]) begin
        v_d[l] = '1;
      end else begin
        v_d[l] = vs[LW-1:0];
      end
    end
  end

  assign stat_o.div_last  = (step_q == LastStep);
  assign stat_o.srch_stop = !cont;
  assign stat_o.mul_last  = (ch_q == LastCh);

  // Control registers.
  logic                          strobe_q;
  logic [pwlcr_pkg::COLOUR_W-1:0] colour_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= pwlcr_pkg::COUNT_RESET;
      k_q        <= '0;
      step_q     <= '0;
      ch_q       <= '0;
      prod_vld_q <= 1'b0;
      strobe_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        count_q <= cfg_wdata_i;
      end
      if (cmd_i.srch_start) begin
        k_q <= AW'(1);
      end else if (cmd_i.srch && cont) begin
        k_q <= k_q + AW'(1);
      end
      if (cmd_i.load1) begin
        step_q <= '0;
      end else if (cmd_i.div_step) begin
        step_q <= step_q + pwlcr_pkg::STEP_W'(1);
      end
      if (cmd_i.load1) begin
        ch_q <= '0;
      end else if (cmd_i.mul_step) begin
        ch_q <= ch_q + 3'd1;
      end
      prod_vld_q <= cmd_i.mul_step && (ch_q != LastCh);
      strobe_q   <= cmd_i.emit;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load1) begin
      den_q <= span_q[LW-1:0];
    end
    if (cmd_i.map_start) begin
      pos_q <= pos_lut[lut_index_i];
    end
    if (cmd_i.srch && !cont) begin
      p1_q <= prdata;
    end
    if (cmd_i.load0) begin
      p0_q <= prdata;
      c1_q <= crdata;
      span_q <= {1'b0, p1_q} - {1'b0, prdata};
    end
    if (cmd_i.load1) begin
      c0_q   <= crdata;
      dneg_q <= dpos[LW];
      dmag_q <= dpos[LW] ? LW'(-dpos) : dpos[LW-1:0];
      span_q <= {1'b0, p1_q} - {1'b0, p0_q};
    end
    if (cmd_i.mul_step && (ch_q != LastCh)) begin
      prod_q     <= {16'b0, dcmag} * {16'b0, dmag_q};
      prod_neg_q <= dc[LW] ^ dneg_q;
      prod_ch_q  <= mul_ch;
    end
    for (int l = 0; l < LANES; l++) begin
      if (prod_vld_q && (prod_ch_q == 2'(l))) begin
        rem_q[l] <= prod_q[31:16];
        quo_q[l] <= prod_q[15:0];
        ovf_q[l] <= ovf;
        neg_q[l] <= prod_neg_q;
      end else if (cmd_i.div_step) begin
        rem_q[l] <= take[l] ? LW'(trial[l] - {1'b0, den_q}) : trial[l][LW-1:0];
        quo_q[l] <= {quo_q[l][LW-2:0], take[l]};
      end
      if (cmd_i.fin) begin
        v_q[l] <= v_d[l];
      end
    end
    if (cmd_i.emit) begin
      colour_q <= {level_to_byte(v_q[3]), level_to_byte(v_q[2]),
                   level_to_byte(v_q[1]), level_to_byte(v_q[0])};
    end
  end

  assign result_strobe_o = strobe_q;
  assign packed_colour_o = colour_q;

endmodule

`default_nettype wire

[src/piecewise_linear_colour_ramp.sv]
// Top level of the piecewise-linear colour ramp.
//
// A request is taken at a rising edge where start is high and busy is low.
// A write request (kind 0) stores one control point in that same edge and
// leaves busy low, so one write can follow each cycle. A map request (kind 1)
// raises busy and, when it is done, puts one packed ABGR colour on
// packed_colour_o with result_strobe_o high for exactly one cycle; that cycle
// is also the first one with busy low again, so a new request can be taken at
// its closing edge. A map request takes its position from a constant table at
// acceptance. One step then starts the segment search, which reads the stored
// positions from the second to at most the last of the N active points, one a
// cycle, with N the point count held to 2..MAX_POINTS. Then come two operand
// loads, the shared multiplier at one channel a cycle, four parallel divider
// lanes, one step to clamp and one to round and pack.
// The point count register is written with cfg_we_i and may only change while
// busy is low. Reset sets the point count to two and returns the controller
// to idle; the point memories hold no reset value and must be written before
// a map request reads them. The receiver cannot stall results.
`default_nettype none

module piecewise_linear_colour_ramp #(
  parameter int MAX_POINTS = pwlcr_pkg::MAX_POINTS_DEF,
  parameter int LUT_SIZE   = pwlcr_pkg::LUT_SIZE_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start,
  output      logic                            busy,
  input  wire logic                            kind_i,
  input  wire logic [pwlcr_pkg::SLOT_W-1:0]    point_slot_i,
  input  wire logic [pwlcr_pkg::LEVEL_W-1:0]   point_position_i,
  input  wire logic [pwlcr_pkg::LEVEL_W-1:0]   red_level_i,
  input  wire logic [pwlcr_pkg::LEVEL_W-1:0]   green_level_i,
  input  wire logic [pwlcr_pkg::LEVEL_W-1:0]   blue_level_i,
  input  wire logic [pwlcr_pkg::LEVEL_W-1:0]   alpha_level_i,
  input  wire logic [pwlcr_pkg::LUT_IDX_W-1:0] lut_index_i,
  input  wire logic                            cfg_we_i,
  input  wire logic [pwlcr_pkg::COUNT_W-1:0]   cfg_wdata_i,
  output      logic                            result_strobe_o,
  output      logic [pwlcr_pkg::COLOUR_W-1:0]  packed_colour_o
);

  pwlcr_pkg::cmd_t    cmd;
  pwlcr_pkg::status_t stat;

  pwlcr_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .kind_i  (kind_i),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  pwlcr_dpath #(
    .MAX_POINTS (MAX_POINTS),
    .LUT_SIZE   (LUT_SIZE)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .point_slot_i     (point_slot_i),
    .point_position_i (point_position_i),
    .red_level_i      (red_level_i),
    .green_level_i    (green_level_i),
    .blue_level_i     (blue_level_i),
    .alpha_level_i    (alpha_level_i),
    .lut_index_i      (lut_index_i),
    .result_strobe_o  (result_strobe_o),
    .packed_colour_o  (packed_colour_o)
  );

endmodule

`default_nettype wire

[src/pwlcr_checker.sv]
// Port-level checker for the colour ramp and its bind to the top level.
`default_nettype none

module pwlcr_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start,
  input wire logic busy,
  input wire logic kind_i,
  input wire logic result_strobe_o
);

  // A result appears only in the cycle where the block is idle again.
  a_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |-> !busy)
    else $error("result strobe while busy");

  // A result lasts a single cycle.
  a_strobe_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |=> !result_strobe_o)
    else $error("result strobe longer than one cycle");

  // A write request completes at once.
  a_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && !kind_i) |=> !busy)
    else $error("write request made the block busy");

  // A map request occupies the block.
  a_map_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && kind_i) |=> busy)
    else $error("map request did not make the block busy");

  // Every end of a map request delivers a result.
  a_end_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> result_strobe_o)
    else $error("map request ended without a result");

endmodule

bind piecewise_linear_colour_ramp pwlcr_checker u_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .kind_i          (kind_i),
  .result_strobe_o (result_strobe_o)
);

`default_nettype wire

[tb/sv/tb.sv]
// Self-checking testbench for the piecewise-linear colour ramp with its own colour predictor.
`timescale 1ns / 1ps

module tb;
  import pwlcr_pkg::*;

  localparam int MAX_POINTS  = MAX_POINTS_DEF;
  localparam int LUT_SIZE    = LUT_SIZE_DEF;
  localparam int CLK_PERIOD  = 10;
  localparam int ITEM_TARGET = 820;
  localparam int STALL_LIMIT = 2000;
  localparam int END_WAIT    = 100;

  typedef struct packed {
    logic                        kind;
    logic [SLOT_W-1:0]           slot;
    logic [LEVEL_W-1:0]          position;
    logic [LANES-1:0][LEVEL_W-1:0] levels;
    logic [LUT_IDX_W-1:0]        lut;
  } ramp_request_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic                 kind_i = KIND_WRITE;
  logic [SLOT_W-1:0]    point_slot_i = '0;
  logic [LEVEL_W-1:0]   point_position_i = '0;
  logic [LEVEL_W-1:0]   red_level_i = '0;
  logic [LEVEL_W-1:0]   green_level_i = '0;
  logic [LEVEL_W-1:0]   blue_level_i = '0;
  logic [LEVEL_W-1:0]   alpha_level_i = '0;
  logic [LUT_IDX_W-1:0] lut_index_i = '0;
  logic                 cfg_we_i = 1'b0;
  logic [COUNT_W-1:0]   cfg_wdata_i = '0;
  logic                 result_strobe_o;
  logic [COLOUR_W-1:0]  packed_colour_o;

  logic [LEVEL_W-1:0]   ramp_positions [MAX_POINTS];
  logic [LEVEL_W-1:0]   ramp_levels [MAX_POINTS][LANES];
  logic [COUNT_W-1:0]   point_count_q = COUNT_RESET;
  logic [COLOUR_W-1:0]  colour_expected_q [$];

  int failures = 0;
  int maps_sent = 0;
  int writes_sent = 0;
  int colours_checked = 0;
  int count_settings = 0;
  int stall_cycles = 0;
  int burst_left = 0;
  bit gap_free = 1'b0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  piecewise_linear_colour_ramp dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .kind_i           (kind_i),
    .point_slot_i     (point_slot_i),
    .point_position_i (point_position_i),
    .red_level_i      (red_level_i),
    .green_level_i    (green_level_i),
    .blue_level_i     (blue_level_i),
    .alpha_level_i    (alpha_level_i),
    .lut_index_i      (lut_index_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .result_strobe_o  (result_strobe_o),
    .packed_colour_o  (packed_colour_o)
  );

  function automatic int active_points(input logic [COUNT_W-1:0] count);
    int n;
    n = int'(count);
    if (n < 2) n = 2;
    if (n > MAX_POINTS) n = MAX_POINTS;
    return n;
  endfunction

  function automatic logic [COLOUR_W-1:0] predict_colour(input logic [LUT_IDX_W-1:0] lut);
    int n;
    int seg;
    longint idx, pos, p0, p1, span, c0, c1, v;
    logic [COLOUR_W-1:0] colour;
    n = active_points(point_count_q);
    idx = longint'(lut);
    if (idx > LUT_SIZE - 1) idx = LUT_SIZE - 1;
    pos = (idx * 65535) / (LUT_SIZE - 1);
    seg = 0;
    while (seg < n - 2 && pos > longint'(ramp_positions[seg + 1])) seg++;
    p0 = longint'(ramp_positions[seg]);
    p1 = longint'(ramp_positions[seg + 1]);
    span = p1 - p0;
    for (int lane = 0; lane < LANES; lane++) begin
      c0 = longint'(ramp_levels[seg][lane]);
      c1 = longint'(ramp_levels[seg + 1][lane]);
      v = c0;
      if (span > 0) v = c0 + ((c1 - c0) * (pos - p0)) / span;
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      colour[8 * lane +: 8] = 8'((v * 255 + 32767) / 65535);
    end
    return colour;
  endfunction

  function automatic logic [LEVEL_W-1:0] random_level();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return LEVEL_W'($urandom);
    endcase
  endfunction

  function automatic ramp_request_t point_write(input logic [SLOT_W-1:0] slot,
                                                input logic [LEVEL_W-1:0] position,
                                                input logic [LEVEL_W-1:0] red,
                                                input logic [LEVEL_W-1:0] green,
                                                input logic [LEVEL_W-1:0] blue,
                                                input logic [LEVEL_W-1:0] alpha);
    ramp_request_t req;
    req.kind = KIND_WRITE;
    req.slot = slot;
    req.position = position;
    req.levels[0] = red;
    req.levels[1] = green;
    req.levels[2] = blue;
    req.levels[3] = alpha;
    req.lut = LUT_IDX_W'($urandom);
    return req;
  endfunction

  function automatic ramp_request_t colour_map(input logic [LUT_IDX_W-1:0] lut);
    ramp_request_t req;
    req.kind = KIND_MAP;
    req.slot = SLOT_W'($urandom);
    req.position = LEVEL_W'($urandom);
    for (int lane = 0; lane < LANES; lane++) req.levels[lane] = LEVEL_W'($urandom);
    req.lut = lut;
    return req;
  endfunction

  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 20);
      gap = gap_free ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic send_request(input ramp_request_t req);
    start <= 1'b1;
    kind_i <= req.kind;
    point_slot_i <= req.slot;
    point_position_i <= req.position;
    red_level_i <= req.levels[0];
    green_level_i <= req.levels[1];
    blue_level_i <= req.levels[2];
    alpha_level_i <= req.levels[3];
    lut_index_i <= req.lut;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (req.kind == KIND_WRITE) begin
      if (int'(req.slot) < MAX_POINTS) begin
        ramp_positions[req.slot] = req.position;
        for (int lane = 0; lane < LANES; lane++) ramp_levels[req.slot][lane] = req.levels[lane];
      end
      writes_sent++;
    end else begin
      colour_expected_q.push_back(predict_colour(req.lut));
      maps_sent++;
    end
    pace();
  endtask

  task automatic settle_idle();
    start <= 1'b0;
    @(posedge clk_i);
    while (colour_expected_q.size() != 0 || busy) @(posedge clk_i);
  endtask

  task automatic write_point_count(input logic [COUNT_W-1:0] value);
    settle_idle();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    point_count_q = value;
    count_settings++;
  endtask

  task automatic test_endpoints();
    send_request(point_write(5'd0, 16'h0000, 16'h0000, 16'hFFFF, 16'h8000, 16'h0001));
    send_request(point_write(5'd1, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h7FFF, 16'hFFFE));
    send_request(colour_map(8'd0));
    send_request(colour_map(8'd1));
    send_request(colour_map(8'd128));
    send_request(colour_map(8'd255));
  endtask

  task automatic test_clamping();
    write_point_count(6'd0);
    send_request(point_write(5'd0, 16'h8000, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF));
    send_request(point_write(5'd1, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF));
    send_request(colour_map(8'd0));
    send_request(colour_map(8'd255));
    write_point_count(6'd1);
    send_request(point_write(5'd0, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000));
    send_request(point_write(5'd1, 16'h4000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000));
    send_request(colour_map(8'd255));
  endtask

  task automatic test_flat_spans();
    write_point_count(6'd3);
    send_request(point_write(5'd0, 16'h1000, random_level(), random_level(), random_level(),
                             random_level()));
    send_request(point_write(5'd1, 16'h1000, random_level(), random_level(), random_level(),
                             random_level()));
    send_request(point_write(5'd2, 16'h0800, random_level(), random_level(), random_level(),
                             random_level()));
    send_request(colour_map(8'd0));
    send_request(colour_map(8'd16));
    send_request(colour_map(8'd255));
  endtask

  task automatic load_ramp(input int n, input bit ordered, input bit pin_ends);
    int spacing;
    int position;
    spacing = 65535 / (n - 1);
    for (int i = 0; i < n; i++) begin
      if (ordered) begin
        position = i * spacing + $urandom_range(0, spacing / 2);
        if (position > 65535) position = 65535;
        if (pin_ends && i == 0) position = 0;
        if (pin_ends && i == n - 1) position = 65535;
      end else begin
        position = $urandom_range(0, 65535);
      end
      send_request(point_write(SLOT_W'(i), LEVEL_W'(position), random_level(), random_level(),
                               random_level(), random_level()));
    end
  endtask

  task automatic test_random_ramps();
    int phase;
    logic [COUNT_W-1:0] count;
    logic [COUNT_W-1:0] first_counts [4];
    first_counts = '{6'd32, 6'd63, 6'd33, 6'd2};
    phase = 0;
    while (maps_sent + writes_sent < ITEM_TARGET) begin
      if (phase < 4) begin
        count = first_counts[phase];
      end else begin
        case ($urandom_range(0, 9))
          0: count = COUNT_W'($urandom_range(0, 1));
          1: count = COUNT_W'($urandom_range(MAX_POINTS + 1, 63));
          2, 3, 4: count = COUNT_W'($urandom_range(2, 6));
          default: count = COUNT_W'($urandom_range(2, MAX_POINTS));
        endcase
      end
      write_point_count(count);
      gap_free = ($urandom_range(0, 3) == 0);
      load_ramp(active_points(count), $urandom_range(0, 7) != 0, $urandom_range(0, 1) == 1);
      repeat ($urandom_range(8, 40)) begin
        if ($urandom_range(0, 11) == 0) begin
          send_request(point_write(SLOT_W'($urandom), LEVEL_W'($urandom), random_level(),
                                   random_level(), random_level(), random_level()));
        end else begin
          send_request(colour_map(LUT_IDX_W'($urandom)));
        end
      end
      phase++;
    end
  endtask

  always @(posedge clk_i) begin : result_check
    logic [COLOUR_W-1:0] expected;
    if (rst_ni && result_strobe_o) begin
      if (colour_expected_q.size() == 0) begin
        $error("packed_colour: no result expected, actual %h", packed_colour_o);
        failures++;
      end else begin
        expected = colour_expected_q.pop_front();
        colours_checked++;
        if (packed_colour_o !== expected) begin
          $error("packed_colour: expected %h, actual %h", expected, packed_colour_o);
          failures++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_strobe_o) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("piecewise_linear_colour_ramp regression: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_endpoints();
    test_clamping();
    test_flat_spans();
    test_random_ramps();
    settle_idle();
    repeat (END_WAIT) @(posedge clk_i);
    if (colour_expected_q.size() != 0) begin
      $error("packed_colour: %0d expected results never arrived", colour_expected_q.size());
      failures++;
    end
    $display("Covered %0d map and %0d point-write requests over %0d point-count settings,",
             maps_sent, writes_sent, count_settings);
    $display("%0d colours checked, with clamped, flat-span and out-of-range counts included.",
             colours_checked);
    if (failures == 0) begin
      $display("piecewise_linear_colour_ramp regression: pass");
    end else begin
      $display("piecewise_linear_colour_ramp regression: fail");
    end
    $finish;
  end

endmodule

[sim.f]
src/pwlcr_pkg.sv
src/pwlcr_ram.sv
src/pwlcr_ctrl.sv
src/pwlcr_dpath.sv
src/piecewise_linear_colour_ramp.sv
src/pwlcr_checker.sv
tb/sv/tb.sv
